FILE: hdl/stt_pkg.sv
// Shared types and codes for the software timer table.
package stt_pkg;

  localparam int unsigned ID_W    = 53;
  localparam int unsigned TIME_W  = 48;
  localparam int unsigned DELAY_W = 32;
  localparam int unsigned LEAST_W = 31;

  localparam logic [ID_W-1:0]    ID_MAX    = {ID_W{1'b1}};
  localparam logic [TIME_W-1:0]  TIME_MAX  = {TIME_W{1'b1}};
  localparam logic [LEAST_W-1:0] DELAY_SAT = {LEAST_W{1'b1}};
  localparam logic signed [DELAY_W-1:0] WAIT_EMPTY = -32'sd1;

  // Operation codes on func_i.
  localparam logic [1:0] FUNC_RUN   = 2'd0;
  localparam logic [1:0] FUNC_SET   = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  // Result status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  // One timer entry as stored in the slot memory.
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [TIME_W-1:0]  deadline;
    logic [DELAY_W-1:0] period;
    logic               periodic;
  } slot_t;

endpackage

FILE: hdl/software_timer_table_unit.sv
// Timer table: slot memory, scan sequencer and result register.
//
// Each request is accepted in the idle state, then passes through a scan
// state in which the single read port of the slot memory walks every slot
// once (one slot per cycle, with registered read data), and a done state in
// which the chosen slot is written back and the result is loaded. The done
// state waits while an earlier result is still held by a stalled receiver.
// The result register lets a new request start while the previous result
// is still waiting to be taken. The per-slot valid flags are flip-flops
// cleared by reset, so no clearing pass is needed after reset.
module software_timer_table_unit #(
  parameter int unsigned MAX_TIMERS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       func_i,
  input  logic [stt_pkg::TIME_W-1:0]       now_ms_i,
  input  logic [stt_pkg::DELAY_W-1:0]      delay_ms_i,
  input  logic                             repeats_i,
  input  logic [stt_pkg::ID_W-1:0]         clear_id_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       status_o,
  output logic [stt_pkg::ID_W-1:0]         new_id_o,
  output logic                             fired_o,
  output logic [stt_pkg::ID_W-1:0]         fired_id_o,
  output logic signed [stt_pkg::DELAY_W-1:0] wait_ms_o
);

  localparam int unsigned IDXW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int unsigned CW   = $clog2(MAX_TIMERS + 1);

  function automatic logic [stt_pkg::TIME_W-1:0] add_time(
    input logic [stt_pkg::TIME_W-1:0]  now,
    input logic [stt_pkg::DELAY_W-1:0] d
  );
    logic [stt_pkg::TIME_W:0] s;
    s = {1'b0, now} + (stt_pkg::TIME_W + 1)'(d);
    return s[stt_pkg::TIME_W] ? stt_pkg::TIME_MAX : s[stt_pkg::TIME_W-1:0];
  endfunction

  stt_pkg::state_e state_q, state_d;

  // Latched request.
  logic [1:0]                  func_q;
  logic [stt_pkg::TIME_W-1:0]  now_q;
  logic [stt_pkg::DELAY_W-1:0] delay_q;
  logic                        rep_q;
  logic [stt_pkg::ID_W-1:0]    tid_q;

  // Scan state.
  logic [CW-1:0]                cnt_q;
  logic                         pend_q;
  logic [IDXW-1:0]              pidx_q;
  logic                         found_q;
  logic                         any_q;
  logic [IDXW-1:0]              sel_q;
  logic [stt_pkg::ID_W-1:0]     best_id_q;
  logic [stt_pkg::DELAY_W-1:0]  best_period_q;
  logic                         best_periodic_q;
  logic [stt_pkg::LEAST_W-1:0]  least_q;

  logic [MAX_TIMERS-1:0]        valid_q;
  logic [stt_pkg::ID_W-1:0]     next_id_q;

  // Slot memory with registered read data.
  stt_pkg::slot_t slot_mem [MAX_TIMERS];
  stt_pkg::slot_t rd_data_q;
  logic           rd_en;
  logic           commit;
  logic           mem_we;
  stt_pkg::slot_t mem_wd;

  // Result register.
  logic                              out_valid_q;
  logic [1:0]                        status_q;
  logic [stt_pkg::ID_W-1:0]          new_id_q;
  logic                              fired_q;
  logic [stt_pkg::ID_W-1:0]          fired_id_q;
  logic signed [stt_pkg::DELAY_W-1:0] wait_ms_q;

  logic                        in_acc;
  logic                        scan_last;
  logic                        slot_v;
  logic [stt_pkg::TIME_W-1:0]  rem;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign scan_last = (cnt_q == CW'(MAX_TIMERS));
  assign slot_v    = valid_q[pidx_q];
  assign rem       = rd_data_q.deadline - now_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      stt_pkg::ST_IDLE: if (in_valid_i) state_d = stt_pkg::ST_SCAN;
      stt_pkg::ST_SCAN: if (scan_last) state_d = stt_pkg::ST_DONE;
      stt_pkg::ST_DONE: if (commit) state_d = stt_pkg::ST_IDLE;
      default:          state_d = stt_pkg::ST_IDLE;
    endcase
  end

  // Control outputs. The slot memory is written only in the done state and
  // read only during a later scan, which keeps accesses from overlapping.
  always_comb begin
    in_stall_o = (state_q != stt_pkg::ST_IDLE);
    rd_en      = (state_q == stt_pkg::ST_SCAN) && !scan_last;
    commit     = (state_q == stt_pkg::ST_DONE) && (!out_valid_q || !out_stall_i);
  end

  // Write-back data for the chosen slot.
  always_comb begin
    mem_we = 1'b0;
    mem_wd = '{id: next_id_q, deadline: add_time(now_q, delay_q),
               period: delay_q, periodic: rep_q};
    if (commit) begin
      if (func_q == stt_pkg::FUNC_SET && found_q) begin
        mem_we = 1'b1;
      end else if (func_q == stt_pkg::FUNC_RUN && found_q && best_periodic_q) begin
        mem_we = 1'b1;
        mem_wd = '{id: best_id_q, deadline: add_time(now_q, best_period_q),
                   period: best_period_q, periodic: 1'b1};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) slot_mem[sel_q] <= mem_wd;
    if (rd_en) rd_data_q <= slot_mem[cnt_q[IDXW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= stt_pkg::ST_IDLE;
      valid_q   <= '0;
      next_id_q <= stt_pkg::ID_W'(1);
      cnt_q     <= '0;
      pend_q    <= 1'b0;
      found_q   <= 1'b0;
      any_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        cnt_q   <= '0;
        pend_q  <= 1'b0;
        found_q <= 1'b0;
        any_q   <= 1'b0;
      end else if (state_q == stt_pkg::ST_SCAN) begin
        pend_q <= rd_en;
        if (rd_en) cnt_q <= cnt_q + CW'(1);
        if (pend_q) begin
          unique case (func_q)
            stt_pkg::FUNC_SET: begin
              if (!slot_v && !found_q) found_q <= 1'b1;
            end
            stt_pkg::FUNC_CLEAR: begin
              if (slot_v && !found_q && tid_q != '0 && rd_data_q.id == tid_q) begin
                found_q <= 1'b1;
              end
            end
            stt_pkg::FUNC_RUN: begin
              if (slot_v) begin
                any_q <= 1'b1;
                if (rd_data_q.deadline <= now_q &&
                    (!found_q || rd_data_q.id < best_id_q)) begin
                  found_q <= 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end
      if (commit) begin
        out_valid_q <= 1'b1;
        if (found_q) begin
          if (func_q == stt_pkg::FUNC_SET) begin
            valid_q[sel_q] <= 1'b1;
            next_id_q <= (next_id_q == stt_pkg::ID_MAX) ? stt_pkg::ID_W'(1)
                                                        : next_id_q + stt_pkg::ID_W'(1);
          end else if (func_q == stt_pkg::FUNC_CLEAR) begin
            valid_q[sel_q] <= 1'b0;
          end else if (func_q == stt_pkg::FUNC_RUN && !best_periodic_q) begin
            valid_q[sel_q] <= 1'b0;
          end
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: latched request, scan candidates and result.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q  <= func_i;
      now_q   <= now_ms_i;
      delay_q <= (delay_ms_i == '0) ? stt_pkg::DELAY_W'(1) : delay_ms_i;
      rep_q   <= repeats_i;
      tid_q   <= clear_id_i;
      least_q <= stt_pkg::DELAY_SAT;
    end else if (state_q == stt_pkg::ST_SCAN) begin
      if (rd_en) pidx_q <= cnt_q[IDXW-1:0];
      if (pend_q) begin
        unique case (func_q)
          stt_pkg::FUNC_SET: begin
            if (!slot_v && !found_q) sel_q <= pidx_q;
          end
          stt_pkg::FUNC_CLEAR: begin
            if (slot_v && !found_q && tid_q != '0 && rd_data_q.id == tid_q) begin
              sel_q <= pidx_q;
            end
          end
          stt_pkg::FUNC_RUN: begin
            if (slot_v) begin
              if (rd_data_q.deadline <= now_q) begin
                if (!found_q || rd_data_q.id < best_id_q) begin
                  sel_q           <= pidx_q;
                  best_id_q       <= rd_data_q.id;
                  best_period_q   <= rd_data_q.period;
                  best_periodic_q <= rd_data_q.periodic;
                end
              end else if (rem < stt_pkg::TIME_W'(least_q)) begin
                least_q <= rem[stt_pkg::LEAST_W-1:0];
              end
            end
          end
          default: ;
        endcase
      end
    end
    if (commit) begin
      status_q    <= stt_pkg::STATUS_OK;
      new_id_q    <= '0;
      fired_q     <= 1'b0;
      fired_id_q  <= '0;
      wait_ms_q   <= '0;
      unique case (func_q)
        stt_pkg::FUNC_SET: begin
          if (found_q) new_id_q <= next_id_q;
          else         status_q <= stt_pkg::STATUS_FULL;
        end
        stt_pkg::FUNC_CLEAR: begin
          if (!found_q) status_q <= stt_pkg::STATUS_NOT_FOUND;
        end
        stt_pkg::FUNC_RUN: begin
          if (!any_q) begin
            wait_ms_q <= stt_pkg::WAIT_EMPTY;
          end else if (found_q) begin
            fired_q    <= 1'b1;
            fired_id_q <= best_id_q;
          end else begin
            wait_ms_q <= signed'({1'b0, least_q});
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign new_id_o    = new_id_q;
  assign fired_o     = fired_q;
  assign fired_id_o  = fired_id_q;
  assign wait_ms_o   = wait_ms_q;

  a_write_only_in_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> state_q == stt_pkg::ST_DONE)
    else $error("slot memory written outside the done state");

  a_next_id_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_id_q != '0)
    else $error("next id became zero");

  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == stt_pkg::ST_SCAN && cnt_q == '0 && !pend_q)
    else $error("accepted request did not start a scan");

  a_fired_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fired_o |-> wait_ms_o == '0 && fired_id_o != '0)
    else $error("fired result carries a nonzero delay or a zero id");

endmodule

FILE: verif/software_timer_table_unit_test.sv
// Self-checking testbench for the software timer table unit.
module software_timer_table_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_TIMERS = 16;
  localparam int unsigned DRAIN_CYCLES = 4 * (MAX_TIMERS + 3);
  localparam int unsigned RANDOM_PER_PHASE = 334;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]                  func;
    logic [stt_pkg::TIME_W-1:0]  now_ms;
    logic [stt_pkg::DELAY_W-1:0] delay_ms;
    logic                        repeats;
    logic [stt_pkg::ID_W-1:0]    clear_id;
  } request_t;

  typedef struct packed {
    logic [1:0]                         status;
    logic [stt_pkg::ID_W-1:0]           new_id;
    logic                               fired;
    logic [stt_pkg::ID_W-1:0]           fired_id;
    logic signed [stt_pkg::DELAY_W-1:0] wait_ms;
  } timer_result_t;

  typedef struct {
    request_t      rq;
    int unsigned   count;
    bit            typed;
    timer_result_t res;
  } stim_row_t;

  logic                               clk_i;
  logic                               rst_ni;
  logic                               in_valid_i;
  logic                               in_stall_o;
  logic [1:0]                         func_i;
  logic [stt_pkg::TIME_W-1:0]         now_ms_i;
  logic [stt_pkg::DELAY_W-1:0]        delay_ms_i;
  logic                               repeats_i;
  logic [stt_pkg::ID_W-1:0]           clear_id_i;
  logic                               out_valid_o;
  logic                               out_stall_i;
  logic [1:0]                         status_o;
  logic [stt_pkg::ID_W-1:0]           new_id_o;
  logic                               fired_o;
  logic [stt_pkg::ID_W-1:0]           fired_id_o;
  logic signed [stt_pkg::DELAY_W-1:0] wait_ms_o;

  software_timer_table_unit #(
    .MAX_TIMERS(MAX_TIMERS)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .now_ms_i    (now_ms_i),
    .delay_ms_i  (delay_ms_i),
    .repeats_i   (repeats_i),
    .clear_id_i  (clear_id_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .new_id_o    (new_id_o),
    .fired_o     (fired_o),
    .fired_id_o  (fired_id_o),
    .wait_ms_o   (wait_ms_o)
  );

  // Predicted contents of the timer table.
  logic                        tbl_valid    [MAX_TIMERS];
  logic [stt_pkg::ID_W-1:0]    tbl_id       [MAX_TIMERS];
  logic [stt_pkg::TIME_W-1:0]  tbl_deadline [MAX_TIMERS];
  logic [stt_pkg::DELAY_W-1:0] tbl_period   [MAX_TIMERS];
  logic                        tbl_periodic [MAX_TIMERS];
  logic [stt_pkg::ID_W-1:0]    tbl_next_id;

  timer_result_t pending_results[$];
  stim_row_t     directed_rows[$];

  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  int unsigned mismatch_count;
  int unsigned request_count;
  int unsigned result_count;
  int unsigned fired_count;
  int unsigned full_count;
  int unsigned cleared_count;
  logic [stt_pkg::TIME_W-1:0] clock_ms;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [stt_pkg::TIME_W-1:0] deadline_after(
    input logic [stt_pkg::TIME_W-1:0]  start,
    input logic [stt_pkg::DELAY_W-1:0] span
  );
    logic [stt_pkg::TIME_W:0] sum;
    sum = {1'b0, start} + {{(stt_pkg::TIME_W + 1 - stt_pkg::DELAY_W){1'b0}}, span};
    return sum[stt_pkg::TIME_W] ? stt_pkg::TIME_MAX : sum[stt_pkg::TIME_W-1:0];
  endfunction

  function automatic timer_result_t timer_table_step(input request_t rq);
    timer_result_t               res;
    int                          free_slot;
    int                          due;
    bit                          any;
    logic [stt_pkg::TIME_W-1:0]  least;
    logic [stt_pkg::TIME_W-1:0]  rem;
    logic [stt_pkg::DELAY_W-1:0] span;
    res = '0;
    free_slot = -1;
    due = -1;
    any = 1'b0;
    least = {{(stt_pkg::TIME_W - stt_pkg::LEAST_W){1'b0}}, stt_pkg::DELAY_SAT};
    case (rq.func)
      stt_pkg::FUNC_SET: begin
        for (int i = 0; i < MAX_TIMERS; i++) begin
          if (!tbl_valid[i]) begin
            free_slot = i;
            break;
          end
        end
        if (free_slot < 0) begin
          res.status = stt_pkg::STATUS_FULL;
        end else begin
          span = (rq.delay_ms == '0) ? stt_pkg::DELAY_W'(1) : rq.delay_ms;
          res.new_id = tbl_next_id;
          tbl_next_id = (tbl_next_id == stt_pkg::ID_MAX) ? stt_pkg::ID_W'(1)
                                                         : tbl_next_id + 1'b1;
          tbl_valid[free_slot]    = 1'b1;
          tbl_id[free_slot]       = res.new_id;
          tbl_deadline[free_slot] = deadline_after(rq.now_ms, span);
          tbl_period[free_slot]   = span;
          tbl_periodic[free_slot] = rq.repeats;
        end
      end
      stt_pkg::FUNC_CLEAR: begin
        res.status = stt_pkg::STATUS_NOT_FOUND;
        if (rq.clear_id != '0) begin
          for (int i = 0; i < MAX_TIMERS; i++) begin
            if (tbl_valid[i] && tbl_id[i] == rq.clear_id) begin
              tbl_valid[i] = 1'b0;
              res.status = stt_pkg::STATUS_OK;
              break;
            end
          end
        end
      end
      stt_pkg::FUNC_RUN: begin
        for (int i = 0; i < MAX_TIMERS; i++) begin
          if (tbl_valid[i]) begin
            any = 1'b1;
            if (tbl_deadline[i] <= rq.now_ms) begin
              if (due < 0 || tbl_id[i] < tbl_id[due]) due = i;
            end else begin
              rem = tbl_deadline[i] - rq.now_ms;
              if (rem < least) least = rem;
            end
          end
        end
        if (!any) begin
          res.wait_ms = stt_pkg::WAIT_EMPTY;
        end else if (due >= 0) begin
          res.fired = 1'b1;
          res.fired_id = tbl_id[due];
          if (tbl_periodic[due]) begin
            tbl_deadline[due] = deadline_after(rq.now_ms, tbl_period[due]);
          end else begin
            tbl_valid[due] = 1'b0;
          end
        end else begin
          res.wait_ms = $signed({1'b0, least[stt_pkg::LEAST_W-1:0]});
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic timer_result_t mk_result(
    input logic [1:0]                         status,
    input logic [stt_pkg::ID_W-1:0]           new_id,
    input logic signed [stt_pkg::DELAY_W-1:0] wait_ms
  );
    timer_result_t res;
    res = '0;
    res.status = status;
    res.new_id = new_id;
    res.wait_ms = wait_ms;
    return res;
  endfunction

  function automatic void add_row(input logic [1:0] func,
                                  input logic [stt_pkg::TIME_W-1:0] now_ms,
                                  input logic [stt_pkg::DELAY_W-1:0] delay_ms,
                                  input logic repeats,
                                  input logic [stt_pkg::ID_W-1:0] clear_id,
                                  input int unsigned count,
                                  input bit typed, input timer_result_t res);
    stim_row_t row;
    row.rq = '{func: func, now_ms: now_ms, delay_ms: delay_ms, repeats: repeats,
               clear_id: clear_id};
    row.count = count;
    row.typed = typed;
    row.res = res;
    directed_rows.push_back(row);
  endfunction

  // Drives one request and waits for it to be taken. Entered and left at a falling edge.
  task automatic send_request(input request_t rq, input bit typed, input timer_result_t res);
    timer_result_t predicted;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    func_i     <= rq.func;
    now_ms_i   <= rq.now_ms;
    delay_ms_i <= rq.delay_ms;
    repeats_i  <= rq.repeats;
    clear_id_i <= rq.clear_id;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = timer_table_step(rq);
    pending_results.push_back(typed ? res : predicted);
    request_count++;
    if (predicted.fired) fired_count++;
    if (rq.func == stt_pkg::FUNC_SET && predicted.status == stt_pkg::STATUS_FULL) begin
      full_count++;
    end
    if (rq.func == stt_pkg::FUNC_CLEAR && predicted.status == stt_pkg::STATUS_OK) begin
      cleared_count++;
    end
    @(negedge clk_i);
  endtask

  function automatic request_t random_request();
    request_t          rq;
    logic [63:0]       wide;
    int unsigned       sel;
    int unsigned       pick;
    int                live[$];
    wide = {$urandom, $urandom};
    rq.func     = stt_pkg::FUNC_RUN;
    rq.now_ms   = clock_ms;
    rq.delay_ms = $urandom;
    rq.repeats  = 1'($urandom_range(1));
    rq.clear_id = wide[stt_pkg::ID_W-1:0];
    sel = $urandom_range(99);
    if (sel < 3) begin
      // Jump the time base, sometimes right up against the end of the time range.
      wide = {$urandom, $urandom};
      clock_ms = $urandom_range(1) ? wide[stt_pkg::TIME_W-1:0]
                                   : stt_pkg::TIME_MAX - $urandom_range(60);
      rq.now_ms = clock_ms;
    end else if (sel < 40) begin
      clock_ms = deadline_after(clock_ms, $urandom_range(25));
      rq.now_ms = clock_ms;
    end else if (sel < 72) begin
      rq.func = stt_pkg::FUNC_SET;
      if ($urandom_range(99) < 88) rq.delay_ms = $urandom_range(40);
    end else if (sel < 90) begin
      rq.func = stt_pkg::FUNC_CLEAR;
      for (int i = 0; i < MAX_TIMERS; i++) begin
        if (tbl_valid[i]) live.push_back(i);
      end
      if (live.size() > 0 && $urandom_range(99) < 80) begin
        pick = $urandom_range(live.size() - 1);
        rq.clear_id = tbl_id[live[pick]];
      end else if ($urandom_range(1)) begin
        rq.clear_id = tbl_next_id - $urandom_range(1, 24);
      end
    end else begin
      wide = {$urandom, $urandom};
      rq.func = 2'($urandom_range(3));
      rq.now_ms = wide[stt_pkg::TIME_W-1:0];
    end
    return rq;
  endfunction

  // The receiver never stalls while reset is applied.
  always @(negedge clk_i) begin
    out_stall_i <= rst_ni && ($urandom_range(99) < receiver_stall_pct);
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    timer_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      result_count++;
      if (pending_results.size() == 0) begin
        $error("result with no request pending: status %0d new_id %0d fired_id %0d",
               status_o, new_id_o, fired_id_o);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 64'(want.status), 64'(status_o));
        check_field("new_id", 64'(want.new_id), 64'(new_id_o));
        check_field("fired", 64'(want.fired), 64'(fired_o));
        check_field("fired_id", 64'(want.fired_id), 64'(fired_id_o));
        if (want.wait_ms !== wait_ms_o) begin
          $error("wait_ms: expected %0d, actual %0d", want.wait_ms, wait_ms_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("software_timer_table_unit test failed");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    func_i      = stt_pkg::FUNC_RUN;
    now_ms_i    = '0;
    delay_ms_i  = '0;
    repeats_i   = 1'b0;
    clear_id_i  = '0;
    mismatch_count = 0;
    request_count  = 0;
    result_count   = 0;
    fired_count    = 0;
    full_count     = 0;
    cleared_count  = 0;
    clock_ms       = '0;
    sender_idle_pct    = 17;
    receiver_stall_pct = 83;
    for (int i = 0; i < MAX_TIMERS; i++) begin
      tbl_valid[i]    = 1'b0;
      tbl_id[i]       = '0;
      tbl_deadline[i] = '0;
      tbl_period[i]   = '0;
      tbl_periodic[i] = 1'b0;
    end
    tbl_next_id = stt_pkg::ID_W'(1);

    // Opening checks on an empty table, then saturation at the end of time,
    // then a full table with many timers due at once.
    add_row(stt_pkg::FUNC_RUN, '0, '0, 1'b0, '0, 1, 1'b1,
            mk_result(stt_pkg::STATUS_OK, '0, stt_pkg::WAIT_EMPTY));
    add_row(stt_pkg::FUNC_CLEAR, '0, '0, 1'b0, '0, 1, 1'b1,
            mk_result(stt_pkg::STATUS_NOT_FOUND, '0, '0));
    add_row(FUNC_UNUSED, stt_pkg::TIME_MAX, '1, 1'b1, stt_pkg::ID_MAX, 1, 1'b1, '0);
    add_row(stt_pkg::FUNC_SET, '0, '0, 1'b0, '0, 1, 1'b1,
            mk_result(stt_pkg::STATUS_OK, stt_pkg::ID_W'(1), '0));
    add_row(stt_pkg::FUNC_RUN, '0, '0, 1'b0, '0, 1, 1'b0, '0);
    add_row(stt_pkg::FUNC_RUN, stt_pkg::TIME_W'(1), '0, 1'b0, '0, 1, 1'b0, '0);
    add_row(stt_pkg::FUNC_SET, stt_pkg::TIME_MAX, '1, 1'b1, '0, 1, 1'b0, '0);
    add_row(stt_pkg::FUNC_RUN, '0, '0, 1'b0, '0, 1, 1'b0, '0);
    add_row(stt_pkg::FUNC_RUN, stt_pkg::TIME_MAX, '0, 1'b0, '0, 2, 1'b0, '0);
    add_row(stt_pkg::FUNC_CLEAR, '0, '0, 1'b0, stt_pkg::ID_W'(2), 1, 1'b0, '0);
    add_row(stt_pkg::FUNC_CLEAR, '0, '0, 1'b0, stt_pkg::ID_MAX, 1, 1'b1,
            mk_result(stt_pkg::STATUS_NOT_FOUND, '0, '0));
    add_row(stt_pkg::FUNC_SET, stt_pkg::TIME_W'(100), stt_pkg::DELAY_W'(5), 1'b0, '0,
            MAX_TIMERS - 2, 1'b0, '0);
    add_row(stt_pkg::FUNC_SET, stt_pkg::TIME_W'(100), stt_pkg::DELAY_W'(3), 1'b1, '0,
            2, 1'b0, '0);
    add_row(stt_pkg::FUNC_SET, stt_pkg::TIME_W'(100), stt_pkg::DELAY_W'(7), 1'b1, '0,
            1, 1'b1, mk_result(stt_pkg::STATUS_FULL, '0, '0));
    add_row(stt_pkg::FUNC_CLEAR, '0, '0, 1'b0, stt_pkg::ID_W'(10), 1, 1'b0, '0);
    add_row(stt_pkg::FUNC_SET, stt_pkg::TIME_W'(100), stt_pkg::DELAY_W'(1), 1'b0, '0,
            1, 1'b0, '0);
    add_row(stt_pkg::FUNC_RUN, stt_pkg::TIME_W'(105), '0, 1'b0, '0, MAX_TIMERS + 1,
            1'b0, '0);
    add_row(stt_pkg::FUNC_RUN, stt_pkg::TIME_W'(200), '0, 1'b0, '0, 4, 1'b0, '0);
    add_row(stt_pkg::FUNC_CLEAR, '0, '0, 1'b0, stt_pkg::ID_W'(17), 1, 1'b0, '0);
    add_row(stt_pkg::FUNC_CLEAR, '0, '0, 1'b0, stt_pkg::ID_W'(18), 1, 1'b0, '0);
    add_row(stt_pkg::FUNC_RUN, stt_pkg::TIME_W'(300), '0, 1'b0, '0, 1, 1'b1,
            mk_result(stt_pkg::STATUS_OK, '0, stt_pkg::WAIT_EMPTY));

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[r]) begin
      repeat (directed_rows[r].count) begin
        send_request(directed_rows[r].rq, directed_rows[r].typed, directed_rows[r].res);
      end
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct = 17;
          receiver_stall_pct = 83;
        end
        1: begin
          sender_idle_pct = 83;
          receiver_stall_pct = 17;
        end
        default: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
        end
      endcase
      repeat (RANDOM_PER_PHASE) send_request(random_request(), 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d requests (%0d results checked): %0d timers fired, %0d sets on a full",
             request_count, result_count, fired_count, full_count);
    $display("table, %0d timers cleared by id, with idle and stall on both sides.",
             cleared_count);
    if (mismatch_count == 0) begin
      $display("software_timer_table_unit test passed");
    end else begin
      $display("software_timer_table_unit test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/stt_pkg.sv
hdl/software_timer_table_unit.sv
verif/software_timer_table_unit_test.sv
